### rtl/core/lqrs_pkg.sv
`default_nettype none

package lqrs_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;

    typedef logic [2:0] t_status;

    localparam t_status ST_TWO    = 3'd0;
    localparam t_status ST_DOUBLE = 3'd1;
    localparam t_status ST_NONE   = 3'd2;
    localparam t_status ST_LINEAR = 3'd3;
    localparam t_status ST_AZERO  = 3'd4;

    typedef struct packed {
        t_status    st;
        logic       calc;
        logic [1:0] neg;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/core/lqrs_sqrt.sv
`default_nettype none

module lqrs_sqrt #(
    parameter int SW       = lqrs_pkg::WORD_BITS_DEF + 1,
    parameter int TAG_BITS = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [2*SW-1:0]     i_rad,
    input  logic [TAG_BITS-1:0] i_tag,
    output logic                o_vld,
    output logic [SW-1:0]       o_root,
    output logic [TAG_BITS-1:0] o_tag
);

    localparam int DW = 2 * SW;

    logic [DW-1:0]       r_rem  [SW];
    logic [SW-1:0]       r_root [SW];
    logic [TAG_BITS-1:0] r_tag  [SW];
    logic                r_vld  [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        localparam int BIT = SW - 1 - k;

        logic [DW-1:0]       w_rem_in;
        logic [DW-1:0]       w_trial;
        logic [SW-1:0]       w_root_in;
        logic [TAG_BITS-1:0] w_tag_in;
        logic                w_vld_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_rad;
            assign w_root_in = '0;
            assign w_tag_in  = i_tag;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_tag_in  = r_tag[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_trial = (DW'(w_root_in) << (BIT + 1)) + (DW'(1) << (2 * BIT));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= w_tag_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[k]  <= w_rem_in - w_trial;
                    r_root[k] <= w_root_in | (SW'(1) << BIT);
                end else begin
                    r_rem[k]  <= w_rem_in;
                    r_root[k] <= w_root_in;
                end
            end
        end
    end

    assign o_vld  = r_vld[SW-1];
    assign o_root = r_root[SW-1];
    assign o_tag  = r_tag[SW-1];

endmodule

`default_nettype wire

### rtl/core/lqrs_div.sv
`default_nettype none

module lqrs_div #(
    parameter int NW        = lqrs_pkg::WORD_BITS_DEF + 2,
    parameter int DNW       = lqrs_pkg::WORD_BITS_DEF + 1,
    parameter int FRAC_BITS = lqrs_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [1:0][NW-1:0]               i_num,
    input  logic [DNW-1:0]                   i_den,
    input  lqrs_pkg::t_ctl                   i_ctl,
    output logic                             o_vld,
    output logic [1:0][NW+FRAC_BITS-1:0]     o_quo,
    output lqrs_pkg::t_ctl                   o_ctl
);

    import lqrs_pkg::*;

    localparam int QW = NW + FRAC_BITS;

    logic [DNW-1:0] r_rem [QW][2];
    logic [QW-1:0]  r_num [QW][2];
    logic [QW-1:0]  r_quo [QW][2];
    logic [DNW-1:0] r_den [QW];
    t_ctl           r_ctl [QW];
    logic           r_vld [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DNW-1:0] w_den_in;
        t_ctl           w_ctl_in;
        logic           w_vld_in;

        if (k == 0) begin : g_first
            assign w_den_in = i_den;
            assign w_ctl_in = i_ctl;
            assign w_vld_in = i_vld;
        end else begin : g_next
            assign w_den_in = r_den[k-1];
            assign w_ctl_in = r_ctl[k-1];
            assign w_vld_in = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den_in;
                r_ctl[k] <= w_ctl_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DNW-1:0] w_rem_in;
            logic [QW-1:0]  w_num_in;
            logic [QW-1:0]  w_quo_in;
            logic [DNW:0]   w_part;
            logic           w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_num_in = QW'(i_num[l]) << FRAC_BITS;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1][l];
                assign w_num_in = r_num[k-1][l];
                assign w_quo_in = r_quo[k-1][l];
            end

            assign w_part = {w_rem_in, w_num_in[QW-1]};
            assign w_ge   = w_part >= {1'b0, w_den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k][l] <= w_num_in << 1;
                    r_quo[k][l] <= {w_quo_in[QW-2:0], w_ge};
                    if (w_ge) begin
                        r_rem[k][l] <= DNW'(w_part - {1'b0, w_den_in});
                    end else begin
                        r_rem[k][l] <= DNW'(w_part);
                    end
                end
            end
        end
    end

    assign o_vld    = r_vld[QW-1];
    assign o_ctl    = r_ctl[QW-1];
    assign o_quo[0] = r_quo[QW-1][0];
    assign o_quo[1] = r_quo[QW-1][1];

endmodule

`default_nettype wire

### rtl/core/linear_quadratic_root_solver.sv
`default_nettype none

// Solves a*x+b=0 (tuser 0) or a*x^2+b*x+c=0 (tuser 1) on signed fixed-point
// coefficients and returns both roots, a status code and an overflow flag;
// roots are truncated toward zero and saturate to the word range. The block is
// a fully pipelined datapath that accepts one item per clock while the output
// is not stalled: input register, multiply, discriminant, a square-root pipeline
// of one stage per root bit (WORD_BITS+1), two stages of numerator setup, a
// restoring divider of one stage per quotient bit (WORD_BITS+2+FRAC_BITS) and
// an output register; roots are Q16.16 at the default parameters. Back pressure
// holds the whole pipeline and reaches tready in the same cycle.
module linear_quadratic_root_solver #(
    parameter int WORD_BITS = lqrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = lqrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // coef_a, coef_b, coef_c
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    // action
    input  logic [0:0]                             i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // root_one, root_two
    output logic [((2*WORD_BITS+7)/8)*8-1:0]       o_m_axis_tdata,
    // status, overflow
    output logic [3:0]                             o_m_axis_tuser
);

    import lqrs_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int OW   = ((2 * W + 7) / 8) * 8;
    localparam int SW   = W + 1;
    localparam int DW   = 2 * SW;
    localparam int NSW  = W + 3;
    localparam int NW   = W + 2;
    localparam int DNW  = W + 1;
    localparam int QW   = NW + FRAC_BITS;
    localparam int TAGW = 2 * W + 3;

    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    logic w_en;

    // input register
    logic                r_s0_vld;
    logic                r_s0_mode;
    logic signed [W-1:0] r_s0_a;
    logic signed [W-1:0] r_s0_b;
    logic signed [W-1:0] r_s0_c;

    // products
    logic                r_s1_vld;
    logic                r_s1_mode;
    logic                r_s1_azero;
    logic                r_s1_acneg;
    logic [2*W-1:0]      r_s1_bb;
    logic [2*W-1:0]      r_s1_ac;
    logic signed [W-1:0] r_s1_a;
    logic signed [W-1:0] r_s1_b;

    // discriminant
    logic                r_s2_vld;
    logic                r_s2_mode;
    logic                r_s2_azero;
    logic                r_s2_noreal;
    logic [DW-1:0]       r_s2_d;
    logic signed [W-1:0] r_s2_a;
    logic signed [W-1:0] r_s2_b;

    // square root
    logic            w_sq_vld;
    logic [SW-1:0]   w_sq_root;
    logic [TAGW-1:0] w_sq_tag;

    // numerators
    logic                  r_s3_vld;
    logic signed [NSW-1:0] r_s3_n1;
    logic signed [NSW-1:0] r_s3_n2;
    logic signed [W:0]     r_s3_den;
    t_status               r_s3_st;
    logic                  r_s3_calc;

    // magnitudes
    logic                  r_s4_vld;
    logic [1:0][NW-1:0]    r_s4_num;
    logic [DNW-1:0]        r_s4_den;
    t_ctl                  r_s4_ctl;

    // output register
    logic                r_out_vld;
    logic [W-1:0]        r_root_one;
    logic [W-1:0]        r_root_two;
    t_status             r_out_st;
    logic                r_out_ovf;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_s_axis_tvalid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= w_sq_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_mode <= i_s_axis_tuser[0];
            r_s0_a    <= i_s_axis_tdata[W-1:0];
            r_s0_b    <= i_s_axis_tdata[2*W-1:W];
            r_s0_c    <= i_s_axis_tdata[3*W-1:2*W];
        end
    end

    logic [W-1:0] w0_amag;
    logic [W-1:0] w0_bmag;
    logic [W-1:0] w0_cmag;

    assign w0_amag = r_s0_a[W-1] ? W'(-r_s0_a) : W'(r_s0_a);
    assign w0_bmag = r_s0_b[W-1] ? W'(-r_s0_b) : W'(r_s0_b);
    assign w0_cmag = r_s0_c[W-1] ? W'(-r_s0_c) : W'(r_s0_c);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mode  <= r_s0_mode;
            r_s1_azero <= r_s0_a == '0;
            r_s1_acneg <= r_s0_a[W-1] ^ r_s0_c[W-1];
            r_s1_bb    <= w0_bmag * w0_bmag;
            r_s1_ac    <= w0_amag * w0_cmag;
            r_s1_a     <= r_s0_a;
            r_s1_b     <= r_s0_b;
        end
    end

    logic [DW-1:0] w1_bb;
    logic [DW-1:0] w1_ac4;

    assign w1_bb  = DW'(r_s1_bb);
    assign w1_ac4 = DW'(r_s1_ac) << 2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_mode   <= r_s1_mode;
            r_s2_azero  <= r_s1_azero;
            r_s2_noreal <= !r_s1_acneg && (w1_bb < w1_ac4);
            r_s2_d      <= r_s1_acneg ? (w1_bb + w1_ac4) : (w1_bb - w1_ac4);
            r_s2_a      <= r_s1_a;
            r_s2_b      <= r_s1_b;
        end
    end

    lqrs_sqrt #(
        .SW       (SW),
        .TAG_BITS (TAGW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_rad   (r_s2_d),
        .i_tag   ({r_s2_mode, r_s2_azero, r_s2_noreal, r_s2_a, r_s2_b}),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_tag   (w_sq_tag)
    );

    logic                  w3_mode;
    logic                  w3_azero;
    logic                  w3_noreal;
    logic [W-1:0]          w3_a;
    logic [W-1:0]          w3_b;
    logic signed [NSW-1:0] w3_sx;
    logic signed [NSW-1:0] w3_bx;
    t_status               w3_st;

    assign w3_b      = w_sq_tag[W-1:0];
    assign w3_a      = w_sq_tag[2*W-1:W];
    assign w3_noreal = w_sq_tag[2*W];
    assign w3_azero  = w_sq_tag[2*W+1];
    assign w3_mode   = w_sq_tag[2*W+2];
    assign w3_sx     = {2'b00, w_sq_root};
    assign w3_bx     = {{3{w3_b[W-1]}}, w3_b};

    always_comb begin
        if (w3_azero) begin
            w3_st = ST_AZERO;
        end else if (w3_mode == MODE_LINEAR) begin
            w3_st = ST_LINEAR;
        end else if (w3_noreal) begin
            w3_st = ST_NONE;
        end else if (w_sq_root == '0) begin
            w3_st = ST_DOUBLE;
        end else begin
            w3_st = ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_st   <= w3_st;
            r_s3_calc <= !w3_azero && !(w3_mode == MODE_QUAD && w3_noreal);
            if (w3_mode == MODE_QUAD) begin
                r_s3_n1  <= w3_sx - w3_bx;
                r_s3_n2  <= -w3_sx - w3_bx;
                r_s3_den <= {w3_a, 1'b0};
            end else begin
                r_s3_n1  <= -w3_bx;
                r_s3_n2  <= '0;
                r_s3_den <= {w3_a[W-1], w3_a};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_num[0]   <= r_s3_n1[NSW-1] ? NW'(-r_s3_n1) : NW'(r_s3_n1);
            r_s4_num[1]   <= r_s3_n2[NSW-1] ? NW'(-r_s3_n2) : NW'(r_s3_n2);
            r_s4_den      <= r_s3_den[W] ? DNW'(-r_s3_den) : DNW'(r_s3_den);
            r_s4_ctl.st   <= r_s3_st;
            r_s4_ctl.calc <= r_s3_calc;
            r_s4_ctl.neg  <= {r_s3_n2[NSW-1] ^ r_s3_den[W], r_s3_n1[NSW-1] ^ r_s3_den[W]};
        end
    end

    logic               w_dv_vld;
    logic [1:0][QW-1:0] w_dv_quo;
    t_ctl               w_dv_ctl;

    lqrs_div #(
        .NW        (NW),
        .DNW       (DNW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s4_vld),
        .i_num   (r_s4_num),
        .i_den   (r_s4_den),
        .i_ctl   (r_s4_ctl),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_ctl   (w_dv_ctl)
    );

    logic [1:0]        w_ovf;
    logic [1:0][W-1:0] w_root;

    for (genvar l = 0; l < 2; l++) begin : g_sat
        logic [QW-1:0] w_lim;
        logic [W-1:0]  w_mag;

        assign w_lim     = w_dv_ctl.neg[l] ? LIM_NEG : LIM_POS;
        assign w_ovf[l]  = w_dv_quo[l] > w_lim;
        assign w_mag     = w_ovf[l] ? w_lim[W-1:0] : w_dv_quo[l][W-1:0];
        assign w_root[l] = w_dv_ctl.neg[l] ? W'(-w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_st <= w_dv_ctl.st;
            if (w_dv_ctl.calc) begin
                r_root_one <= w_root[0];
                r_root_two <= w_root[1];
                r_out_ovf  <= |w_ovf;
            end else begin
                r_root_one <= '0;
                r_root_two <= '0;
                r_out_ovf  <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OW'({r_root_two, r_root_one});
    assign o_m_axis_tuser  = {r_out_ovf, r_out_st};

    a_none_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == ST_NONE) |-> (r_root_one == '0 && r_root_two == '0 && !r_out_ovf))
        else $error("no-real-root item carries roots");

    a_azero_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == ST_AZERO) |-> (r_root_one == '0 && r_root_two == '0 && !r_out_ovf))
        else $error("zero leading coefficient item carries roots");

    a_double_same : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == ST_DOUBLE) |-> (r_root_one == r_root_two))
        else $error("double root differs between lanes");

    a_linear_two : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == ST_LINEAR) |-> (r_root_two == '0))
        else $error("linear item has a second root");

endmodule

`default_nettype wire
